// ===== src/wca_pkg.sv =====
// ----------------------------------------------------------------------------
// wca_pkg
// Shared types, widths and tables for the wind angle circular averager.
// ----------------------------------------------------------------------------
package wca_pkg;

  localparam int RING_DEPTH   = 20;
  localparam int TRIG_BITS    = 16;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int SUM_W        = TRIG_BITS + $clog2(RING_DEPTH) + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int XY_W         = 40;
  localparam int Z_W          = 26;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  // warning codes
  localparam logic [1:0] WARN_NONE  = 2'd0;
  localparam logic [1:0] WARN_CLOSE = 2'd1;
  localparam logic [1:0] WARN_DEAD  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_CLOSE  = 2'd1;
  localparam logic [1:0] REG_DEAD   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic              load;
    logic              step;
    logic              ring_upd;
    logic              vec_init;
    logic              avg_calc;
    logic              out_load;
    logic [STEP_W-1:0] step_idx;
  } wca_cmd_t;

  // atan(2^-i) in degrees scaled by 2^16
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = Z_W'(2949120);
      5'd1:    r = Z_W'(1740967);
      5'd2:    r = Z_W'(919879);
      5'd3:    r = Z_W'(466945);
      5'd4:    r = Z_W'(234379);
      5'd5:    r = Z_W'(117304);
      5'd6:    r = Z_W'(58666);
      5'd7:    r = Z_W'(29335);
      5'd8:    r = Z_W'(14668);
      5'd9:    r = Z_W'(7334);
      5'd10:   r = Z_W'(3667);
      5'd11:   r = Z_W'(1833);
      5'd12:   r = Z_W'(917);
      5'd13:   r = Z_W'(458);
      5'd14:   r = Z_W'(229);
      5'd15:   r = Z_W'(115);
      5'd16:   r = Z_W'(57);
      5'd17:   r = Z_W'(29);
      5'd18:   r = Z_W'(14);
      5'd19:   r = Z_W'(7);
      5'd20:   r = Z_W'(4);
      5'd21:   r = Z_W'(2);
      5'd22:   r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/wca_ctrl.sv =====
// ----------------------------------------------------------------------------
// wca_ctrl
// Sequencer: accepts an item, runs the shared cordic in rotation then
// vectoring mode, and hands the result to the output register.
// ----------------------------------------------------------------------------
module wca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output wca_pkg::wca_cmd_t cmd_o
);
  import wca_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROT   = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_VINIT = 3'd3;
  localparam logic [2:0] ST_VEC   = 3'd4;
  localparam logic [2:0] ST_AVG   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              ovalid_q, ovalid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.step_idx = cnt_q;
    s_axis_tready  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.ring_upd = 1'b1;
        state_d        = ST_VINIT;
      end
      ST_VINIT: begin
        cmd_o.vec_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_VEC;
      end
      ST_VEC: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) state_d = ST_AVG;
      end
      ST_AVG: begin
        cmd_o.avg_calc = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    ovalid_d = ovalid_q;
    if (m_axis_tready) ovalid_d = 1'b0;
    if (cmd_o.out_load) ovalid_d = 1'b1;
  end

  assign m_axis_tvalid = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== src/wca_datapath.sv =====
// ----------------------------------------------------------------------------
// wca_datapath
// Offset correction, shared cordic, sample ring with running sums, mean
// rounding, zone classification and the output register.
// ----------------------------------------------------------------------------
module wca_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wca_pkg::wca_cmd_t cmd_i,
  input  logic [8:0]        raw_angle_i,
  input  logic [8:0]        angle_offset_i,
  input  logic [7:0]        close_hauled_limit_i,
  input  logic [7:0]        dead_run_limit_i,
  output logic [8:0]        corrected_angle_o,
  output logic [8:0]        mean_angle_o,
  output logic [1:0]        warning_o
);
  import wca_pkg::*;

  // ring and sums
  logic signed [TRIG_BITS-1:0] sin_ring_q [RING_DEPTH];
  logic signed [TRIG_BITS-1:0] cos_ring_q [RING_DEPTH];
  logic [RING_DEPTH-1:0]       ring_vld_q;
  logic [PTR_W-1:0]            wpos_q;
  logic signed [SUM_W-1:0]     sin_sum_q, cos_sum_q;

  // cordic
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic                   vec_mode_q;
  logic                   zero_q;

  // per-item registers
  logic [8:0] ang_q;
  logic [1:0] quad_q;
  logic [8:0] avg_q;
  logic [8:0] out_corr_q, out_avg_q;
  logic [1:0] out_warn_q;

  // offset correction and quadrant split
  logic [9:0] asum, asum1;
  logic [8:0] ang, rem;
  logic [1:0] quad;

  always_comb begin
    asum  = {1'b0, raw_angle_i} + {1'b0, angle_offset_i};
    asum1 = (asum >= 10'd360) ? asum - 10'd360 : asum;
    ang   = (asum1 >= 10'd360) ? 9'(asum1 - 10'd360) : asum1[8:0];
    if (ang >= 9'd270) begin
      quad = 2'd3; rem = ang - 9'd270;
    end else if (ang >= 9'd180) begin
      quad = 2'd2; rem = ang - 9'd180;
    end else if (ang >= 9'd90) begin
      quad = 2'd1; rem = ang - 9'd90;
    end else begin
      quad = 2'd0; rem = ang;
    end
  end

  // one cordic micro-rotation
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  at;
  logic                   pos_dir;

  always_comb begin
    dx = y_q >>> cmd_i.step_idx;
    dy = x_q >>> cmd_i.step_idx;
    at = atan_deg(cmd_i.step_idx);
    pos_dir = vec_mode_q ? !(y_q > 0) : (z_q >= 0);
  end

  // quadrant mapping and rounding to trig format
  logic signed [XY_W-1:0]      sv_raw, cv_raw;
  logic signed [XY_W-1:0]      sv_rnd, cv_rnd;
  logic signed [TRIG_BITS-1:0] sv, cv;
  logic signed [TRIG_BITS-1:0] sin_old, cos_old;

  localparam logic signed [XY_W-1:0] RND_ADD = XY_W'(1) <<< (30 - TRIG_BITS);
  localparam logic signed [XY_W-1:0] Q_TOP   = (XY_W'(1) <<< (TRIG_BITS - 1)) - 1;
  localparam logic signed [XY_W-1:0] Q_BOT   = -(XY_W'(1) <<< (TRIG_BITS - 1));

  always_comb begin
    case (quad_q)
      2'd0:    begin sv_raw = y_q;  cv_raw = x_q;  end
      2'd1:    begin sv_raw = x_q;  cv_raw = -y_q; end
      2'd2:    begin sv_raw = -y_q; cv_raw = -x_q; end
      default: begin sv_raw = -x_q; cv_raw = y_q;  end
    endcase
    sv_rnd = (sv_raw + RND_ADD) >>> (31 - TRIG_BITS);
    cv_rnd = (cv_raw + RND_ADD) >>> (31 - TRIG_BITS);
    if (sv_rnd > Q_TOP)      sv = TRIG_BITS'(Q_TOP);
    else if (sv_rnd < Q_BOT) sv = TRIG_BITS'(Q_BOT);
    else                     sv = sv_rnd[TRIG_BITS-1:0];
    if (cv_rnd > Q_TOP)      cv = TRIG_BITS'(Q_TOP);
    else if (cv_rnd < Q_BOT) cv = TRIG_BITS'(Q_BOT);
    else                     cv = cv_rnd[TRIG_BITS-1:0];
    sin_old = ring_vld_q[wpos_q] ? sin_ring_q[wpos_q] : '0;
    cos_old = ring_vld_q[wpos_q] ? cos_ring_q[wpos_q] : '0;
  end

  // vector start from the sums
  logic signed [XY_W-1:0] sx_ext, sy_ext;

  always_comb begin
    sx_ext = XY_W'(cos_sum_q) <<< (31 - TRIG_BITS);
    sy_ext = XY_W'(sin_sum_q) <<< (31 - TRIG_BITS);
  end

  // mean angle rounding and wrap
  logic signed [Z_W-1:0] z_rnd;
  logic signed [10:0]    d;
  logic [8:0]            avg_d;

  always_comb begin
    z_rnd = (z_q + Z_W'(32768)) >>> 16;
    d     = z_rnd[10:0];
    if (d < 0)                avg_d = 9'(d + 11'sd360);
    else if (d >= 11'sd360)   avg_d = 9'(d - 11'sd360);
    else                      avg_d = d[8:0];
    if (zero_q) avg_d = '0;
  end

  // zone classification
  logic signed [10:0] a_s, cl_s, dr_s;
  logic [1:0]         warn;

  always_comb begin
    a_s  = {2'b00, avg_q};
    cl_s = {3'b000, close_hauled_limit_i};
    dr_s = {3'b000, dead_run_limit_i};
    if (a_s < cl_s || a_s > 11'sd360 - cl_s)                   warn = WARN_CLOSE;
    else if (a_s > 11'sd180 - dr_s && a_s < 11'sd180 + dr_s)  warn = WARN_DEAD;
    else                                                       warn = WARN_NONE;
  end

  // control state of the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      wpos_q     <= '0;
      sin_sum_q  <= '0;
      cos_sum_q  <= '0;
    end else if (cmd_i.ring_upd) begin
      ring_vld_q[wpos_q] <= 1'b1;
      wpos_q    <= (wpos_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
      sin_sum_q <= sin_sum_q + SUM_W'(sv) - SUM_W'(sin_old);
      cos_sum_q <= cos_sum_q + SUM_W'(cv) - SUM_W'(cos_old);
    end
  end

  // ring entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_upd) begin
      sin_ring_q[wpos_q] <= sv;
      cos_ring_q[wpos_q] <= cv;
    end
  end

  // cordic registers and per-item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ang_q      <= ang;
      quad_q     <= quad;
      x_q        <= CORDIC_GAIN;
      y_q        <= '0;
      z_q        <= Z_W'({rem, 16'h0000});
      vec_mode_q <= 1'b0;
    end else if (cmd_i.vec_init) begin
      vec_mode_q <= 1'b1;
      zero_q     <= (sin_sum_q == '0) && (cos_sum_q == '0);
      if (cos_sum_q < 0) begin
        x_q <= -sx_ext;
        y_q <= -sy_ext;
        z_q <= Z_W'(180 * 65536);
      end else begin
        x_q <= sx_ext;
        y_q <= sy_ext;
        z_q <= '0;
      end
    end else if (cmd_i.step) begin
      if (pos_dir) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (cmd_i.avg_calc) avg_q <= avg_d;
    if (cmd_i.out_load) begin
      out_corr_q <= ang_q;
      out_avg_q  <= avg_q;
      out_warn_q <= warn;
    end
  end

  assign corrected_angle_o = out_corr_q;
  assign mean_angle_o      = out_avg_q;
  assign warning_o         = out_warn_q;

endmodule

// ===== src/wind_angle_circular_averager.sv =====
// ----------------------------------------------------------------------------
// wind_angle_circular_averager
// Offset-corrects vane angles and reports their circular mean and a zone
// warning.
// ----------------------------------------------------------------------------
// Each item goes from acceptance to the output register through one shared
// cordic, which runs 24 iterations for sine and cosine and 24 more for the
// atan2 of the running sums, with steps between for ring update, vector
// set-up, mean rounding and classification. One item is worked at a time;
// the next is accepted only after the result has moved to the output
// register. While the output register still holds an item that is not
// taken, the finished result waits and the input stays closed. The sample
// ring needs no clearing pass after reset: per-entry valid bits make
// unwritten entries read as zero.
module wind_angle_circular_averager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // raw_angle[8:0], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // corrected_angle[8:0], mean_angle[17:9],
                                      // warning[19:18], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wca_pkg::*;

  logic [8:0] offset_q;
  logic [7:0] close_q, dead_q;
  logic [1:0] reg_idx;
  wca_cmd_t   cmd;
  logic [8:0] corr, avg;
  logic [1:0] warn;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 9'd1;
      close_q  <= 8'd30;
      dead_q   <= 8'd15;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_OFFSET: offset_q <= pwdata[8:0];
        REG_CLOSE:  close_q  <= pwdata[7:0];
        REG_DEAD:   dead_q   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_OFFSET: prdata = {23'b0, offset_q};
      REG_CLOSE:  prdata = {24'b0, close_q};
      REG_DEAD:   prdata = {24'b0, dead_q};
      default:    prdata = '0;
    endcase
  end

  wca_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  wca_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .raw_angle_i          (s_axis_tdata[8:0]),
    .angle_offset_i       (offset_q),
    .close_hauled_limit_i (close_q),
    .dead_run_limit_i     (dead_q),
    .corrected_angle_o    (corr),
    .mean_angle_o         (avg),
    .warning_o            (warn)
  );

  assign m_axis_tdata = {4'b0000, warn, avg, corr};

endmodule
